// ===== rtl/oal_pkg.sv =====
// Shared types, codes and constants for the ordered array list.
package oal_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 5;
    localparam int KEY_W        = 64;
    localparam int VOTE_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int LEN_W        = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_READ   = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_UPDATE = 3'd5
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_BADPOS = 2'd2,
        ST_NOKEY  = 2'd3
    } t_status;

    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
    } t_cell_ctrl;

endpackage

// ===== rtl/oal_if.sv =====
// Request and result channel interfaces of the ordered array list.
interface oal_req_if import oal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    position;
    logic [KEY_W-1:0]    entry_key;
    logic [VOTE_W-1:0]   vote_count;
    logic                clear_list;

    modport source (output valid, cmd, position, entry_key, vote_count, clear_list,
                    input ready);
    modport sink   (input valid, cmd, position, entry_key, vote_count, clear_list,
                    output ready);
endinterface

interface oal_rsp_if import oal_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    found_position;
    logic [KEY_W-1:0]    read_key;
    logic [VOTE_W-1:0]   read_votes;
    logic [LEN_W-1:0]    list_length;

    modport source (output valid, status, found_position, read_key, read_votes,
                    list_length, input ready);
    modport sink   (input valid, status, found_position, read_key, read_votes,
                    list_length, output ready);
endinterface

// ===== rtl/ordered_array_list.sv =====
// Top level of the ordered array list: command decode, cell row and result register.
// Every request completes in the cycle it is accepted; its result is registered and
// appears in the next cycle, and 1 request per cycle is taken while each result is taken.
// A new request is taken while the held result is being taken in the same cycle.
// The shift, match and read chains through the row of cells set the cycle time.
// Reset empties the list; entry contents are not cleared and are never read unwritten.
module ordered_array_list import oal_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    oal_req_if.sink   i_in,
    oal_rsp_if.source o_out
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    t_status           r_status;
    logic [POS_W-1:0]  r_fpos;
    logic [KEY_W-1:0]  r_rkey;
    logic [VOTE_W-1:0] r_rvotes;
    t_status           n_status;
    logic [POS_W-1:0]  n_fpos;
    logic [KEY_W-1:0]  n_rkey;
    logic [VOTE_W-1:0] n_rvotes;

    logic              in_fire;
    logic              full;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    t_cell_ctrl        ctrl;
    logic [IDX_W-1:0]  target;

    logic [KEY_W-1:0]  cell_key   [CAPACITY];
    logic [VOTE_W-1:0] cell_votes [CAPACITY];
    logic              seen_ch    [CAPACITY+1];
    logic [IDX_W-1:0]  fidx_ch    [CAPACITY+1];
    logic [KEY_W-1:0]  rkey_ch    [CAPACITY+1];
    logic [VOTE_W-1:0] rvotes_ch  [CAPACITY+1];

    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;
    assign full       = (r_count == CAP_CNT);
    assign pos_ext    = CMP_W'(i_in.position);
    assign cnt_ext    = CMP_W'(r_count);

    always_comb begin
        ctrl     = '0;
        target   = IDX_W'(i_in.position);
        n_count  = r_count;
        n_status = ST_OK;
        n_fpos   = '0;
        n_rkey   = '0;
        n_rvotes = '0;
        if (i_in.clear_list) begin
            n_count = '0;
        end else begin
            unique case (t_cmd'(i_in.cmd))
                CMD_INSERT: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else if (pos_ext > cnt_ext) begin
                        n_status = ST_BADPOS;
                    end else begin
                        ctrl.ins = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_APPEND: begin
                    target = IDX_W'(r_count);
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctrl.ins = 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end
                CMD_DELETE: begin
                    if (pos_ext >= cnt_ext) begin
                        n_status = ST_BADPOS;
                    end else begin
                        ctrl.del = 1'b1;
                        n_count  = r_count - 1'b1;
                    end
                end
                CMD_READ: begin
                    if (pos_ext >= cnt_ext) begin
                        n_status = ST_BADPOS;
                    end else begin
                        n_rkey   = rkey_ch[CAPACITY];
                        n_rvotes = rvotes_ch[CAPACITY];
                    end
                end
                CMD_FIND: begin
                    if (seen_ch[CAPACITY]) begin
                        n_fpos = POS_W'(fidx_ch[CAPACITY]);
                    end else begin
                        n_status = ST_NOKEY;
                    end
                end
                CMD_UPDATE: begin
                    if (pos_ext >= cnt_ext) begin
                        n_status = ST_BADPOS;
                    end else begin
                        ctrl.upd = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (!in_fire) begin
            ctrl = '0;
        end
    end

    assign seen_ch[0]   = 1'b0;
    assign fidx_ch[0]   = '0;
    assign rkey_ch[0]   = '0;
    assign rvotes_ch[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [KEY_W-1:0]  below_key;
        logic [VOTE_W-1:0] below_votes;
        logic [KEY_W-1:0]  above_key;
        logic [VOTE_W-1:0] above_votes;

        if (g == 0) begin : g_bottom
            assign below_key   = '0;
            assign below_votes = '0;
        end else begin : g_mid_lo
            assign below_key   = cell_key[g-1];
            assign below_votes = cell_votes[g-1];
        end
        if (g == CAPACITY - 1) begin : g_top
            assign above_key   = '0;
            assign above_votes = '0;
        end else begin : g_mid_hi
            assign above_key   = cell_key[g+1];
            assign above_votes = cell_votes[g+1];
        end

        oal_cell #(
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .INDEX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_target      (target),
            .i_count       (r_count),
            .i_new_key     (i_in.entry_key),
            .i_new_votes   (i_in.vote_count),
            .i_below_key   (below_key),
            .i_below_votes (below_votes),
            .i_above_key   (above_key),
            .i_above_votes (above_votes),
            .i_find_key    (i_in.entry_key),
            .i_seen        (seen_ch[g]),
            .i_fidx        (fidx_ch[g]),
            .i_rd_key      (rkey_ch[g]),
            .i_rd_votes    (rvotes_ch[g]),
            .o_key         (cell_key[g]),
            .o_votes       (cell_votes[g]),
            .o_seen        (seen_ch[g+1]),
            .o_fidx        (fidx_ch[g+1]),
            .o_rd_key      (rkey_ch[g+1]),
            .o_rd_votes    (rvotes_ch[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status <= n_status;
            r_fpos   <= n_fpos;
            r_rkey   <= n_rkey;
            r_rvotes <= n_rvotes;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.found_position = r_fpos;
    assign o_out.read_key       = r_rkey;
    assign o_out.read_votes     = r_rvotes;
    assign o_out.list_length    = LEN_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_ctrl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({ctrl.ins, ctrl.del, ctrl.upd}))
        else $error("more than one cell operation at once");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in.clear_list |=> r_count == '0)
        else $error("clear did not empty the list");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_status == ST_FULL |-> r_count == CAP_CNT)
        else $error("full status reported on a list that is not full");

endmodule

// ===== rtl/oal_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors and joins the read and match chains.
module oal_cell import oal_pkg::*; #(
    parameter int IDX_W = 5,
    parameter int CNT_W = 6,
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctrl        i_ctrl,
    input  logic [IDX_W-1:0]  i_target,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [KEY_W-1:0]  i_new_key,
    input  logic [VOTE_W-1:0] i_new_votes,
    input  logic [KEY_W-1:0]  i_below_key,
    input  logic [VOTE_W-1:0] i_below_votes,
    input  logic [KEY_W-1:0]  i_above_key,
    input  logic [VOTE_W-1:0] i_above_votes,
    input  logic [KEY_W-1:0]  i_find_key,
    input  logic              i_seen,
    input  logic [IDX_W-1:0]  i_fidx,
    input  logic [KEY_W-1:0]  i_rd_key,
    input  logic [VOTE_W-1:0] i_rd_votes,
    output logic [KEY_W-1:0]  o_key,
    output logic [VOTE_W-1:0] o_votes,
    output logic              o_seen,
    output logic [IDX_W-1:0]  o_fidx,
    output logic [KEY_W-1:0]  o_rd_key,
    output logic [VOTE_W-1:0] o_rd_votes
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

    logic [KEY_W-1:0]  r_key;
    logic [VOTE_W-1:0] r_votes;
    logic [KEY_W-1:0]  n_key;
    logic [VOTE_W-1:0] n_votes;
    logic              sel;
    logic              above_target;
    logic              hit;
    logic              first;

    assign sel          = (MY_IDX == i_target);
    assign above_target = (MY_IDX > i_target);
    assign hit          = (MY_CNT < i_count) && (r_key == i_find_key);
    assign first        = hit && !i_seen;

    always_comb begin
        n_key   = r_key;
        n_votes = r_votes;
        if (i_ctrl.ins) begin
            if (above_target) begin
                n_key   = i_below_key;
                n_votes = i_below_votes;
            end else if (sel) begin
                n_key   = i_new_key;
                n_votes = i_new_votes;
            end
        end
        if (i_ctrl.del && (above_target || sel)) begin
            n_key   = i_above_key;
            n_votes = i_above_votes;
        end
        if (i_ctrl.upd && sel) begin
            n_votes = i_new_votes;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_votes <= n_votes;
    end

    assign o_key      = r_key;
    assign o_votes    = r_votes;
    assign o_seen     = i_seen | hit;
    assign o_fidx     = i_fidx | (first ? MY_IDX : '0);
    assign o_rd_key   = i_rd_key | (sel ? r_key : '0);
    assign o_rd_votes = i_rd_votes | (sel ? r_votes : '0);

endmodule

// ===== sim/ordered_array_list_test.sv =====
// Self-checking testbench for the ordered array list: random and directed list commands.
module ordered_array_list_test;
    import oal_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 5;
    localparam int LIMIT_CYCLES   = 200_000;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int TAIL_CYCLES    = 4;
    localparam int KEY_POOL_SIZE  = 6;
    localparam int PHASE_ITEMS    = 317;
    localparam int FULL_LINGER    = 6;
    localparam int POS_MAX        = (1 << POS_W) - 1;

    localparam logic [CMD_W-1:0]  CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_7 = 3'd7;
    localparam logic [KEY_W-1:0]  KEY_ONES    = '1;
    localparam logic [VOTE_W-1:0] VOTE_ONES   = '1;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  key;
        logic [VOTE_W-1:0] votes;
        logic              clear;
    } list_request_t;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  found_pos;
        logic [KEY_W-1:0]  read_key;
        logic [VOTE_W-1:0] read_votes;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    class ordered_list_tracker;
        localparam int SLOTS = DEF_CAPACITY;

        logic [KEY_W-1:0]  shadow_keys[SLOTS];
        logic [VOTE_W-1:0] shadow_votes[SLOTS];
        int unsigned       shadow_count;
        list_result_t      pending_results[$];
        int unsigned       result_index;
        int unsigned       mismatch_count;

        function new();
            shadow_count   = 0;
            result_index   = 0;
            mismatch_count = 0;
        endfunction

        function void put_entry(int unsigned slot, logic [KEY_W-1:0] key,
                                logic [VOTE_W-1:0] votes);
            for (int unsigned i = shadow_count; i > slot; i--) begin
                shadow_keys[i]  = shadow_keys[i-1];
                shadow_votes[i] = shadow_votes[i-1];
            end
            shadow_keys[slot]  = key;
            shadow_votes[slot] = votes;
            shadow_count++;
        endfunction

        function void note_request(list_request_t req);
            list_result_t res;
            bit           hit;
            res.status     = ST_OK;
            res.found_pos  = '0;
            res.read_key   = '0;
            res.read_votes = '0;
            hit            = 1'b0;
            if (req.clear) begin
                shadow_count = 0;
            end else begin
                case (req.cmd)
                    CMD_INSERT: begin
                        if (shadow_count >= SLOTS) res.status = ST_FULL;
                        else if (req.position > shadow_count) res.status = ST_BADPOS;
                        else put_entry(req.position, req.key, req.votes);
                    end
                    CMD_APPEND: begin
                        if (shadow_count >= SLOTS) res.status = ST_FULL;
                        else put_entry(shadow_count, req.key, req.votes);
                    end
                    CMD_DELETE: begin
                        if (req.position >= shadow_count) begin
                            res.status = ST_BADPOS;
                        end else begin
                            for (int unsigned i = req.position; i + 1 < shadow_count; i++) begin
                                shadow_keys[i]  = shadow_keys[i+1];
                                shadow_votes[i] = shadow_votes[i+1];
                            end
                            shadow_count--;
                        end
                    end
                    CMD_READ: begin
                        if (req.position >= shadow_count) begin
                            res.status = ST_BADPOS;
                        end else begin
                            res.read_key   = shadow_keys[req.position];
                            res.read_votes = shadow_votes[req.position];
                        end
                    end
                    CMD_FIND: begin
                        res.status = ST_NOKEY;
                        for (int unsigned i = 0; i < shadow_count; i++) begin
                            if (!hit && shadow_keys[i] == req.key) begin
                                hit           = 1'b1;
                                res.status    = ST_OK;
                                res.found_pos = POS_W'(i);
                            end
                        end
                    end
                    CMD_UPDATE: begin
                        if (req.position >= shadow_count) res.status = ST_BADPOS;
                        else shadow_votes[req.position] = req.votes;
                    end
                    default: begin
                    end
                endcase
            end
            res.length = LEN_W'(shadow_count);
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [KEY_W-1:0] want,
                             logic [KEY_W-1:0] got);
            $display("result %0d: %s mismatch, expected %0h, got %0h",
                     result_index, what, want, got);
            mismatch_count++;
        endtask

        task check_result(list_result_t got);
            list_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result", '0, got.status);
                result_index++;
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", want.status, got.status);
            if (got.found_pos !== want.found_pos)
                report_mismatch("found_position", want.found_pos, got.found_pos);
            if (got.read_key !== want.read_key)
                report_mismatch("read_key", want.read_key, got.read_key);
            if (got.read_votes !== want.read_votes)
                report_mismatch("read_votes", want.read_votes, got.read_votes);
            if (got.length !== want.length)
                report_mismatch("list_length", want.length, got.length);
            result_index++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    oal_req_if in_ch ();
    oal_rsp_if out_ch ();

    ordered_array_list #(
        .CAPACITY (DEF_CAPACITY)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ordered_list_tracker tracker;
    logic [KEY_W-1:0]    key_pool[KEY_POOL_SIZE];
    int unsigned         tx_idle_pct;
    int unsigned         rx_idle_pct;
    bit                  rx_hold_pending;
    int unsigned         rx_hold_left;
    bit                  growing;
    int unsigned         full_visits;

    always begin
        i_clk = 1'b0;
        #(CLK_PERIOD / 2);
        i_clk = 1'b1;
        #(CLK_PERIOD / 2);
    end

    initial begin
        out_ch.ready = 1'b0;
        rx_hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_pending) begin
                rx_hold_pending = 1'b0;
                rx_hold_left    = RX_HOLD_CYCLES;
            end
            if (rx_hold_left != 0) begin
                out_ch.ready = 1'b0;
                rx_hold_left--;
            end else begin
                out_ch.ready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            tracker.check_result('{status:     t_status'(out_ch.status),
                                   found_pos:  out_ch.found_position,
                                   read_key:   out_ch.read_key,
                                   read_votes: out_ch.read_votes,
                                   length:     out_ch.list_length});
        end
    end

    function automatic list_request_t make_request(logic [CMD_W-1:0] cmd,
                                                   int unsigned position,
                                                   logic [KEY_W-1:0] key,
                                                   logic [VOTE_W-1:0] votes,
                                                   logic clear);
        list_request_t req;
        req.cmd      = cmd;
        req.position = POS_W'(position);
        req.key      = key;
        req.votes    = votes;
        req.clear    = clear;
        return req;
    endfunction

    function automatic list_request_t random_request();
        list_request_t req;
        int unsigned   roll;
        int unsigned   fill;
        fill      = tracker.shadow_count;
        roll      = $urandom_range(99);
        req.clear = 1'b0;
        req.votes = $urandom;
        case ($urandom_range(3))
            0:       req.key = {$urandom, $urandom};
            1:       req.key = ($urandom_range(1) != 0) ? KEY_ONES : '0;
            default: req.key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        endcase
        if (roll < 1) begin
            req.clear = 1'b1;
            req.cmd   = CMD_W'($urandom_range(7));
        end else if (roll < 3) begin
            req.cmd = ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
        end else if (growing) begin
            if (roll < 35) req.cmd = CMD_INSERT;
            else if (roll < 60) req.cmd = CMD_APPEND;
            else if (roll < 68) req.cmd = CMD_DELETE;
            else if (roll < 78) req.cmd = CMD_READ;
            else if (roll < 90) req.cmd = CMD_FIND;
            else req.cmd = CMD_UPDATE;
        end else begin
            if (roll < 10) req.cmd = CMD_INSERT;
            else if (roll < 18) req.cmd = CMD_APPEND;
            else if (roll < 48) req.cmd = CMD_DELETE;
            else if (roll < 62) req.cmd = CMD_READ;
            else if (roll < 80) req.cmd = CMD_FIND;
            else req.cmd = CMD_UPDATE;
        end
        if ($urandom_range(4) == 0)
            req.position = POS_W'($urandom_range(POS_MAX));
        else if (req.cmd == CMD_INSERT)
            req.position = POS_W'((fill > POS_MAX) ? POS_MAX : $urandom_range(fill));
        else
            req.position = POS_W'((fill == 0) ? 0 : $urandom_range(fill - 1));
        if (req.cmd == CMD_FIND && fill != 0 && $urandom_range(9) < 6)
            req.key = tracker.shadow_keys[$urandom_range(fill - 1)];
        return req;
    endfunction

    task automatic send_request(input list_request_t req);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      = 1'b1;
        in_ch.cmd        = req.cmd;
        in_ch.position   = req.position;
        in_ch.entry_key  = req.key;
        in_ch.vote_count = req.votes;
        in_ch.clear_list = req.clear;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        tracker.note_request(req);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        in_ch.valid = 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_random_phase(int unsigned tx_pct, int unsigned rx_pct);
        tx_idle_pct     = tx_pct;
        rx_idle_pct     = rx_pct;
        rx_hold_pending = 1'b1;
        repeat (PHASE_ITEMS) begin
            send_request(random_request());
            if (growing && tracker.shadow_count >= DEF_CAPACITY) full_visits++;
            if (growing && full_visits >= FULL_LINGER) begin
                growing     = 1'b0;
                full_visits = 0;
            end else if (!growing && tracker.shadow_count == 0) begin
                growing = 1'b1;
            end
        end
        wait_for_results();
    endtask

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("ordered_array_list test failed");
        $finish;
    end

    initial begin
        tracker          = new();
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = '0;
        in_ch.position   = '0;
        in_ch.entry_key  = '0;
        in_ch.vote_count = '0;
        in_ch.clear_list = 1'b0;
        tx_idle_pct      = 0;
        rx_idle_pct      = 0;
        rx_hold_pending  = 1'b0;
        growing          = 1'b1;
        full_visits      = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(make_request(CMD_READ, 0, KEY_ONES, VOTE_ONES, 1'b0));
        send_request(make_request(CMD_FIND, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_DELETE, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_UPDATE, 0, '0, VOTE_ONES, 1'b0));
        send_request(make_request(CMD_APPEND, POS_MAX, KEY_ONES, VOTE_ONES, 1'b0));
        send_request(make_request(CMD_APPEND, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_INSERT, 0, key_pool[0], $urandom, 1'b0));
        send_request(make_request(CMD_INSERT, 2, key_pool[1], $urandom, 1'b0));
        send_request(make_request(CMD_INSERT, 4, key_pool[0], $urandom, 1'b0));
        send_request(make_request(CMD_INSERT, POS_MAX, key_pool[2], $urandom, 1'b0));
        send_request(make_request(CMD_INSERT, 6, key_pool[2], $urandom, 1'b0));
        send_request(make_request(CMD_FIND, 3, key_pool[0], '0, 1'b0));
        send_request(make_request(CMD_FIND, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_FIND, 0, key_pool[2], '0, 1'b0));
        send_request(make_request(CMD_READ, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_READ, 4, '0, '0, 1'b0));
        send_request(make_request(CMD_READ, 5, '0, '0, 1'b0));
        send_request(make_request(CMD_UPDATE, 1, '0, VOTE_ONES, 1'b0));
        send_request(make_request(CMD_UPDATE, 5, '0, '0, 1'b0));
        send_request(make_request(CMD_DELETE, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_DELETE, 3, '0, '0, 1'b0));
        send_request(make_request(CMD_DELETE, POS_MAX, '0, '0, 1'b0));
        send_request(make_request(CMD_SPARE_6, 0, KEY_ONES, VOTE_ONES, 1'b0));
        send_request(make_request(CMD_SPARE_7, 1, '0, '0, 1'b0));
        send_request(make_request(CMD_APPEND, POS_MAX, KEY_ONES, VOTE_ONES, 1'b1));
        send_request(make_request(CMD_READ, 0, '0, '0, 1'b0));
        send_request(make_request(CMD_FIND, 0, key_pool[1], '0, 1'b0));
        wait_for_results();

        run_random_phase(38, 81);
        run_random_phase(81, 38);
        run_random_phase(0, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0) begin
            $display("ordered_array_list test passed");
        end else begin
            $display("ordered_array_list test failed");
        end
        $finish;
    end

endmodule

// ===== ordered_array_list.f =====
rtl/oal_pkg.sv
rtl/oal_if.sv
rtl/oal_cell.sv
rtl/ordered_array_list.sv
sim/ordered_array_list_test.sv
